### hdl/hcbp_pkg.sv
// shared types and constants for the huffman code bit packer
package hcbp_pkg;

   localparam int SYM_W  = 8;
   localparam int LEN_W  = 6;
   localparam int CODE_W = 32;
   localparam int MODE_W = 2;
   localparam int POS_W  = 3;

   localparam int DEF_MAX_CODE_LEN = 32;
   localparam int DEF_NUM_SYMBOLS  = 256;

   localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;

   typedef struct packed {
      logic              en;
      logic [SYM_W-1:0]  symbol;
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] bits;
   } hcbp_wr_type;

endpackage

### hdl/hcbp_code_table.sv
// code table: length and left-aligned code memories with per-entry valid bits
module hcbp_code_table #(
   parameter int NUM_SYMBOLS = hcbp_pkg::DEF_NUM_SYMBOLS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  hcbp_pkg::hcbp_wr_type        wr,
   input  logic                         rd_en,
   input  logic [hcbp_pkg::SYM_W-1:0]   rd_symbol,
   output logic [hcbp_pkg::LEN_W-1:0]   rd_len,
   output logic [hcbp_pkg::CODE_W-1:0]  rd_bits
);
   import hcbp_pkg::*;

   localparam int IDX_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

   logic [LEN_W-1:0]       len_mem  [NUM_SYMBOLS];
   logic [CODE_W-1:0]      bits_mem [NUM_SYMBOLS];
   logic [NUM_SYMBOLS-1:0] vld_ff, vld_in;
   logic [IDX_W-1:0]       wr_idx, rd_idx;
   logic [LEN_W-1:0]       rd_len_ff;
   logic [CODE_W-1:0]      rd_bits_ff;
   logic                   rd_vld_ff;

   assign wr_idx = wr.symbol[IDX_W-1:0];
   assign rd_idx = rd_symbol[IDX_W-1:0];

   always_comb begin
      vld_in = vld_ff;
      if (wr.en) begin
         vld_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         len_mem[wr_idx]  <= wr.len;
         bits_mem[wr_idx] <= wr.bits;
      end
      if (rd_en) begin
         rd_len_ff  <= len_mem[rd_idx];
         rd_bits_ff <= bits_mem[rd_idx];
         rd_vld_ff  <= vld_ff[rd_idx];
      end
   end

   // never-written entries read as length zero
   assign rd_len  = rd_vld_ff ? rd_len_ff : '0;
   assign rd_bits = rd_bits_ff;

endmodule

### hdl/huffman_code_bit_packer_unit.sv
// huffman code bit packer top level: bit-serial packer with output register
//
//   channel   dir   ports                                            handshake
//   req       in    mode symbol code_length code_value               valid / stall
//   rsp       out   packed_byte byte_present flush_report            valid / stall
//                   trash_bits last
//
// load: the table is written as the item is taken. encode: a registered table read,
// then one code bit per cycle through the shift register, held while a byte waits.
// flush: one report item. a completed byte waits in place while the output register
// is stalled. reset clears the valid bits at once, no clearing pass; lengths read zero.
// one item is worked on at a time; req_stall stays high until it is done.
module huffman_code_bit_packer_unit #(
   parameter int MAX_CODE_LEN = hcbp_pkg::DEF_MAX_CODE_LEN,
   parameter int NUM_SYMBOLS  = hcbp_pkg::DEF_NUM_SYMBOLS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [hcbp_pkg::MODE_W-1:0]  req_mode,
   input  logic [hcbp_pkg::SYM_W-1:0]   req_symbol,
   input  logic [hcbp_pkg::LEN_W-1:0]   req_code_length,
   input  logic [hcbp_pkg::CODE_W-1:0]  req_code_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_packed_byte,
   output logic                         rsp_byte_present,
   output logic                         rsp_flush_report,
   output logic [hcbp_pkg::POS_W-1:0]   rsp_trash_bits,
   output logic                         rsp_last
);
   import hcbp_pkg::*;

   localparam int               CAP     = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
   localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAP);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_SHIFT = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CODE_W-1:0] shift_ff, shift_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [7:0]        acc_ff, acc_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              rng_ff, rng_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_present_ff, rsp_present_in;
   logic              rsp_flush_ff, rsp_flush_in;
   logic [POS_W-1:0]  rsp_trash_ff, rsp_trash_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              req_take, in_range, out_free, out_load;
   logic [LEN_W-1:0]  len_sat, shamt, tbl_len;
   logic [CODE_W-1:0] tbl_bits;
   logic [7:0]        acc_bit;
   hcbp_wr_type       tbl_wr;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign in_range  = ({1'b0, req_symbol} < 9'(NUM_SYMBOLS));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // saturate and left-align the code so the first bit sits in the msb
   assign len_sat = (req_code_length > CAP_LEN) ? CAP_LEN : req_code_length;
   assign shamt   = LEN_W'(CODE_W) - len_sat;

   always_comb begin
      tbl_wr.en     = req_take && (req_mode == MODE_LOAD) && in_range;
      tbl_wr.symbol = req_symbol;
      tbl_wr.len    = len_sat;
      tbl_wr.bits   = req_code_value << shamt;
   end

   hcbp_code_table #(
      .NUM_SYMBOLS (NUM_SYMBOLS)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .wr        (tbl_wr),
      .rd_en     (req_take && (req_mode == MODE_ENCODE)),
      .rd_symbol (req_symbol),
      .rd_len    (tbl_len),
      .rd_bits   (tbl_bits)
   );

   assign acc_bit = acc_ff | ({7'd0, shift_ff[CODE_W-1]} << pos_ff);

   always_comb begin
      state_in       = state_ff;
      shift_in       = shift_ff;
      cnt_in         = cnt_ff;
      acc_in         = acc_ff;
      pos_in         = pos_ff;
      rng_in         = rng_ff;
      out_load       = 1'b0;
      rsp_byte_in    = rsp_byte_ff;
      rsp_present_in = rsp_present_ff;
      rsp_flush_in   = rsp_flush_ff;
      rsp_trash_in   = rsp_trash_ff;
      rsp_last_in    = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_mode == MODE_ENCODE) begin
                  state_in = ST_READ;
                  rng_in   = in_range;
               end else if (req_mode == MODE_FLUSH) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_READ: begin
            shift_in = tbl_bits;
            cnt_in   = rng_ff ? tbl_len : '0;
            state_in = (rng_ff && (tbl_len != '0)) ? ST_SHIFT : ST_IDLE;
         end
         ST_SHIFT: begin
            if (pos_ff != '0) begin
               acc_in   = acc_bit;
               pos_in   = pos_ff - 1'b1;
               shift_in = shift_ff << 1;
               cnt_in   = cnt_ff - 1'b1;
            end else if (out_free) begin
               out_load       = 1'b1;
               rsp_byte_in    = acc_bit;
               rsp_present_in = 1'b1;
               rsp_flush_in   = 1'b0;
               rsp_trash_in   = '0;
               rsp_last_in    = (cnt_ff < 6'd9);
               acc_in         = '0;
               pos_in         = 3'd7;
               shift_in       = shift_ff << 1;
               cnt_in         = cnt_ff - 1'b1;
            end
            if (cnt_in == '0) begin
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               out_load       = 1'b1;
               rsp_present_in = (pos_ff != 3'd7);
               rsp_byte_in    = (pos_ff != 3'd7) ? acc_ff : '0;
               rsp_trash_in   = (pos_ff != 3'd7) ? (pos_ff + 1'b1) : '0;
               rsp_flush_in   = 1'b1;
               rsp_last_in    = 1'b1;
               acc_in         = '0;
               pos_in         = 3'd7;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         pos_ff       <= 3'd7;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff       <= shift_in;
      rng_ff         <= rng_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_present_ff <= rsp_present_in;
      rsp_flush_ff   <= rsp_flush_in;
      rsp_trash_ff   <= rsp_trash_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_packed_byte  = rsp_byte_ff;
   assign rsp_byte_present = rsp_present_ff;
   assign rsp_flush_report = rsp_flush_ff;
   assign rsp_trash_bits   = rsp_trash_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_shift_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (cnt_ff != '0))
      else $error("shift state with no bits left");

   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_flush_ff) |-> rsp_last_ff)
      else $error("flush report not marked last");

   a_no_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_present_ff) |-> (rsp_flush_ff && (rsp_trash_ff == '0)
         && (rsp_byte_ff == '0)))
      else $error("empty item that is not an empty flush report");

   a_encode_read: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_mode == MODE_ENCODE)) |=> (state_ff == ST_READ))
      else $error("encode item did not start a table read");

   a_flush_clear: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FLUSH) && out_free) |=> ((pos_ff == 3'd7) && (acc_ff == '0)))
      else $error("packer not restarted after flush");
`endif

endmodule
